FILE: sv/drb_pkg.sv
// Shared types and constants for the detection box regression block.
// No dependencies; imported by the controller, datapath and top level.
`default_nettype none

package drb_pkg;

  localparam int MAX_COMPONENTS = 8;
  localparam int MAX_PARTS      = 8;
  // height term, then top and left of the root and of every part
  localparam int TERMS          = 1 + 2 * (1 + MAX_PARTS);
  localparam int COEF_DEPTH     = MAX_COMPONENTS * TERMS;   // words per edge set
  localparam int COEF_AW        = $clog2(COEF_DEPTH);
  localparam int POS_W          = $clog2(TERMS + 1);
  localparam int NUM_EDGES      = 4;

  localparam int COMP_W   = 3;
  localparam int IDX_W    = 5;
  localparam int SEL_W    = 2;
  localparam int COEF_W   = 32;
  localparam int COORD_W  = 16;
  localparam int VAL_W    = COORD_W + 1;            // bottom - top
  localparam int PROD_W   = VAL_W + COEF_W;
  localparam int ACC_W    = 64;
  localparam int FRAC_W   = 20;                     // Q4 coords * Q16 coefs
  localparam int EDGE_W   = 12;
  localparam int RATIO_W  = 16;
  localparam int RATIO_FR = 12;
  localparam int ORIG_W   = 16;
  localparam int CFG_IW   = 2;
  localparam int CFG_DW   = 16;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_BOX  = 1'b1;

  localparam logic [CFG_IW-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_RATIO_RECIP  = 2'd2;

  localparam logic [EDGE_W-1:0]  RST_IMAGE_WIDTH  = 12'd640;
  localparam logic [EDGE_W-1:0]  RST_IMAGE_HEIGHT = 12'd480;
  localparam logic [RATIO_W-1:0] RST_RATIO_RECIP  = 16'd4096;

  typedef enum logic [1:0] {
    TERM_HEIGHT,
    TERM_TOP,
    TERM_LEFT
  } term_t;

  typedef struct packed {
    logic  load_wr;
    logic  take_item;
    logic  issue;
    term_t term;
    logic  edge_calc;
    logic  rescale;
    logic  out_load;
    logic  restart;
  } drb_cmd_t;

  typedef struct packed {
    logic root;
    logic out_free;
  } drb_sts_t;

endpackage

`default_nettype wire

FILE: sv/detection_box_regression_top.sv
// Detection box regression: a box word issues its top and left terms (a root
// box issues the height term first) into the coefficient RAM read port;
// terms then finish through a read stage and a multiply stage. The last box
// of a detection then drains, clamps, rescales and loads the output, and waits
// while the previous result is still held. Coefficient load words are written
// while idle. Coefficients live in four RAMs, one per edge set, addressed by
// component * terms + term position; a word that was never loaded reads as
// garbage. The output register holds one result, so the next word is taken
// while a result waits.
// Depends on drb_pkg, drb_ctrl, drb_datapath and drb_ram.
`default_nettype none

module detection_box_regression_top (
  input  wire logic         clk,
  input  wire logic         rst_n,
  // in_tdata, lowest bit up: component[2:0], coef_index[7:3], coef_select[9:8],
  // coef_value[41:10], box_left[57:42], box_top[73:58], box_bottom[89:74],
  // score[105:90], scale[121:106], zero pad
  input  wire logic [127:0] in_tdata,
  input  wire logic         in_tuser,   // op: 0 coefficient load, 1 box
  input  wire logic         in_tlast,   // last_box
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // out_tdata, lowest bit up: left[11:0], top[23:12], right[35:24],
  // bottom[47:36], orig_left[63:48], orig_top[79:64], orig_right[95:80],
  // orig_bottom[111:96], out_component[114:112], out_score[130:115],
  // out_scale[146:131], zero pad
  output logic [151:0]      out_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [15:0]  cfg_data
);
  import drb_pkg::*;

  drb_cmd_t cmd;
  drb_sts_t sts;

  logic [EDGE_W-1:0]  edge_q [NUM_EDGES];
  logic [ORIG_W-1:0]  orig_q [NUM_EDGES];
  logic [COMP_W-1:0]  comp_q;
  logic [COORD_W-1:0] score_q, scale_q;

  assign cfg_ready = 1'b1;

  drb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  drb_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .cfg_wr      (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .component   (in_tdata[2:0]),
    .coef_index  (in_tdata[7:3]),
    .coef_select (in_tdata[9:8]),
    .coef_value  (in_tdata[41:10]),
    .box_left    (in_tdata[57:42]),
    .box_top     (in_tdata[73:58]),
    .box_bottom  (in_tdata[89:74]),
    .score       (in_tdata[105:90]),
    .scale       (in_tdata[121:106]),
    .out_tready  (out_tready),
    .out_tvalid  (out_tvalid),
    .edge_q      (edge_q),
    .orig_q      (orig_q),
    .comp_q      (comp_q),
    .score_q     (score_q),
    .scale_q     (scale_q)
  );

  assign out_tdata = {5'd0, scale_q, score_q, comp_q,
                      orig_q[3], orig_q[2], orig_q[1], orig_q[0],
                      edge_q[3], edge_q[2], edge_q[1], edge_q[0]};

endmodule

`default_nettype wire

FILE: sv/drb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module drb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 152
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

FILE: sv/drb_ctrl.sv
// Sequencer for the box regression: accepts words, steps terms through
// the datapath and finishes a detection. Depends on drb_pkg.
`default_nettype none

module drb_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  input  wire logic             in_tuser,
  input  wire logic             in_tlast,
  output logic                  in_tready,
  input  wire drb_pkg::drb_sts_t sts,
  output drb_pkg::drb_cmd_t     cmd
);
  import drb_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ISSUE,
    S_DRAIN1,
    S_DRAIN2,
    S_EDGE,
    S_SCALE,
    S_OUT
  } state_t;

  state_t state_r, state_nxt;
  term_t  term_r, term_nxt;
  logic   last_r, last_nxt;

  always_comb begin
    state_nxt = state_r;
    term_nxt  = term_r;
    last_nxt  = last_r;
    cmd       = '0;
    cmd.term  = term_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          if (in_tuser == OP_BOX) begin
            cmd.take_item = 1'b1;
            term_nxt      = sts.root ? TERM_HEIGHT : TERM_TOP;
            last_nxt      = in_tlast;
            state_nxt     = S_ISSUE;
          end else begin
            cmd.load_wr = 1'b1;
          end
        end
      end
      S_ISSUE: begin
        cmd.issue = 1'b1;
        unique case (term_r)
          TERM_HEIGHT: term_nxt = TERM_TOP;
          TERM_TOP:    term_nxt = TERM_LEFT;
          default:     state_nxt = last_r ? S_DRAIN1 : S_IDLE;
        endcase
      end
      // DRAIN1 and DRAIN2 let the read and multiply stages empty
      S_DRAIN1: state_nxt = S_DRAIN2;
      S_DRAIN2: state_nxt = S_EDGE;
      S_EDGE: begin
        cmd.edge_calc = 1'b1;
        state_nxt     = S_SCALE;
      end
      S_SCALE: begin
        cmd.rescale = 1'b1;
        state_nxt   = S_OUT;
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.restart  = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      term_r  <= TERM_HEIGHT;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      term_r  <= term_nxt;
      last_r  <= last_nxt;
    end
  end

  assign in_tready = (state_r == S_IDLE);

  a_out_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> sts.out_free)
    else $error("result loaded while output word still pending");

  a_scale_after_edge: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rescale |-> $past(cmd.edge_calc))
    else $error("rescale without fresh edges");

endmodule

`default_nettype wire

FILE: sv/drb_datapath.sv
// Datapath: coefficient RAMs, term multipliers, edge accumulators, clamping,
// rescale and the output register. Depends on drb_pkg and drb_ram.
`default_nettype none

module drb_datapath (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire drb_pkg::drb_cmd_t             cmd,
  output drb_pkg::drb_sts_t                  sts,
  input  wire logic                          cfg_wr,
  input  wire logic [drb_pkg::CFG_IW-1:0]    cfg_index,
  input  wire logic [drb_pkg::CFG_DW-1:0]    cfg_data,
  input  wire logic [drb_pkg::COMP_W-1:0]    component,
  input  wire logic [drb_pkg::IDX_W-1:0]     coef_index,
  input  wire logic [drb_pkg::SEL_W-1:0]     coef_select,
  input  wire logic [drb_pkg::COEF_W-1:0]    coef_value,
  input  wire logic [drb_pkg::COORD_W-1:0]   box_left,
  input  wire logic [drb_pkg::COORD_W-1:0]   box_top,
  input  wire logic [drb_pkg::COORD_W-1:0]   box_bottom,
  input  wire logic [drb_pkg::COORD_W-1:0]   score,
  input  wire logic [drb_pkg::COORD_W-1:0]   scale,
  input  wire logic                          out_tready,
  output logic                               out_tvalid,
  output logic [drb_pkg::EDGE_W-1:0]         edge_q [drb_pkg::NUM_EDGES],
  output logic [drb_pkg::ORIG_W-1:0]         orig_q [drb_pkg::NUM_EDGES],
  output logic [drb_pkg::COMP_W-1:0]         comp_q,
  output logic [drb_pkg::COORD_W-1:0]        score_q,
  output logic [drb_pkg::COORD_W-1:0]        scale_q
);
  import drb_pkg::*;

  function automatic logic [EDGE_W-1:0] floor_edge(input logic signed [ACC_W-1:0] acc);
    logic [EDGE_W-1:0] res;
    if (acc <= 0) begin
      res = '0;
    end else if (|acc[ACC_W-2:FRAC_W+EDGE_W]) begin
      res = '1;
    end else begin
      res = acc[FRAC_W+EDGE_W-1:FRAC_W];
    end
    return res;
  endfunction

  function automatic logic [EDGE_W-1:0] cap_edge(input logic signed [ACC_W-1:0] acc,
                                                 input logic [EDGE_W-1:0] limit);
    logic signed [ACC_W-1:0] lim_ext;
    logic [EDGE_W-1:0]       res;
    lim_ext = {{(ACC_W-EDGE_W-FRAC_W){1'b0}}, limit, {FRAC_W{1'b0}}};
    if (acc >= lim_ext) begin
      res = limit;
    end else if (acc <= 0) begin
      res = '0;
    end else begin
      res = acc[FRAC_W+EDGE_W-1:FRAC_W];
    end
    return res;
  endfunction

  // configuration
  logic [EDGE_W-1:0]  img_w_r, img_h_r;
  logic [RATIO_W-1:0] ratio_r;

  // current box
  logic [COMP_W-1:0]  comp_r;
  logic [COORD_W-1:0] left_r, top_r, bottom_r, score_r, scale_r;
  logic [POS_W-1:0]   pos_r, pos_nxt;

  // term pipeline
  logic                     term_ok;
  logic signed [VAL_W-1:0]  val_nxt, val1_r;
  logic                     v1_r, v2_r;
  logic [COEF_W-1:0]        coef_rd [NUM_EDGES];
  logic signed [PROD_W-1:0] prod_r [NUM_EDGES];
  logic signed [ACC_W-1:0]  acc_r [NUM_EDGES];

  logic [COEF_AW-1:0] wr_addr, rd_addr;
  logic               load_ok;

  logic [EDGE_W-1:0]  edge_r [NUM_EDGES];
  logic [ORIG_W-1:0]  orig_r [NUM_EDGES];
  logic               out_valid_r;
  logic [EDGE_W-1:0]  out_edge_r [NUM_EDGES];
  logic [ORIG_W-1:0]  out_orig_r [NUM_EDGES];
  logic [COMP_W-1:0]  out_comp_r;
  logic [COORD_W-1:0] out_score_r, out_scale_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_w_r <= RST_IMAGE_WIDTH;
      img_h_r <= RST_IMAGE_HEIGHT;
      ratio_r <= RST_RATIO_RECIP;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH:  img_w_r <= cfg_data[EDGE_W-1:0];
        CFG_IMAGE_HEIGHT: img_h_r <= cfg_data[EDGE_W-1:0];
        CFG_RATIO_RECIP:  ratio_r <= cfg_data[RATIO_W-1:0];
        default: ;
      endcase
    end
  end

  // coefficient loads go straight from the input word to the RAMs
  assign load_ok = cmd.load_wr && (int'(component) < MAX_COMPONENTS)
                   && (int'(coef_index) < TERMS);
  assign wr_addr = COEF_AW'(int'(component) * TERMS + int'(coef_index));
  assign rd_addr = COEF_AW'(int'(comp_r) * TERMS + int'(pos_r));

  for (genvar s = 0; s < NUM_EDGES; s++) begin : g_coef
    drb_ram #(
      .WIDTH (COEF_W),
      .DEPTH (COEF_DEPTH)
    ) u_coef_ram (
      .clk     (clk),
      .wr_en   (load_ok && (int'(coef_select) == s)),
      .wr_addr (wr_addr),
      .wr_data (coef_value),
      .rd_addr (rd_addr),
      .rd_data (coef_rd[s])
    );
  end

  // terms past the last coefficient are dropped and the position holds
  assign term_ok = cmd.issue && (int'(pos_r) < TERMS);

  always_comb begin
    val_nxt = '0;
    case (cmd.term)
      TERM_HEIGHT: val_nxt = $signed({bottom_r[COORD_W-1], bottom_r})
                             - $signed({top_r[COORD_W-1], top_r});
      TERM_TOP:    val_nxt = $signed({top_r[COORD_W-1], top_r});
      TERM_LEFT:   val_nxt = $signed({left_r[COORD_W-1], left_r});
      default:     val_nxt = '0;
    endcase
  end

  always_comb begin
    pos_nxt = pos_r;
    if (cmd.restart) begin
      pos_nxt = '0;
    end else if (term_ok) begin
      pos_nxt = pos_r + POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      for (int s = 0; s < NUM_EDGES; s++) begin
        acc_r[s] <= '0;
      end
    end else begin
      pos_r <= pos_nxt;
      v1_r  <= term_ok;
      v2_r  <= v1_r;
      for (int s = 0; s < NUM_EDGES; s++) begin
        if (cmd.restart) begin
          acc_r[s] <= '0;
        end else if (v2_r) begin
          acc_r[s] <= acc_r[s] + {{(ACC_W-PROD_W){prod_r[s][PROD_W-1]}}, prod_r[s]};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_item) begin
      comp_r   <= component;
      left_r   <= box_left;
      top_r    <= box_top;
      bottom_r <= box_bottom;
      score_r  <= score;
      scale_r  <= scale;
    end
    val1_r <= val_nxt;
    for (int s = 0; s < NUM_EDGES; s++) begin
      prod_r[s] <= val1_r * $signed(coef_rd[s]);
    end
    if (cmd.edge_calc) begin
      edge_r[0] <= floor_edge(acc_r[0]);
      edge_r[1] <= floor_edge(acc_r[1]);
      edge_r[2] <= cap_edge(acc_r[2], img_w_r);
      edge_r[3] <= cap_edge(acc_r[3], img_h_r);
    end
    if (cmd.rescale) begin
      for (int s = 0; s < NUM_EDGES; s++) begin
        // 12 x 16 bit product stays below 2^28, so the top 16 bits never overflow
        orig_r[s] <= ORIG_W'((({{RATIO_W{1'b0}}, edge_r[s]} * {{EDGE_W{1'b0}}, ratio_r})
                              >> RATIO_FR));
      end
    end
    if (cmd.out_load) begin
      out_edge_r  <= edge_r;
      out_orig_r  <= orig_r;
      out_comp_r  <= comp_r;
      out_score_r <= score_r;
      out_scale_r <= scale_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign sts.root     = (pos_r == '0);
  assign sts.out_free = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign edge_q     = out_edge_r;
  assign orig_q     = out_orig_r;
  assign comp_q     = out_comp_r;
  assign score_q    = out_score_r;
  assign scale_q    = out_scale_r;

  a_pos_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    int'(pos_r) <= TERMS)
    else $error("term position past the coefficient table");

  a_height_on_root: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.issue && cmd.term == TERM_HEIGHT) |-> (pos_r == '0))
    else $error("height term issued on a part box");

  a_restart_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.restart |-> (!v1_r && !v2_r))
    else $error("accumulators cleared with terms still in flight");

endmodule

`default_nettype wire

FILE: dv/detection_box_regression_top_tb.sv
`timescale 1ns / 100ps
// Testbench for detection_box_regression_top: fills the coefficient memory, streams
// detections under random stalls on both sides and checks every refined box word.
// Depends on drb_pkg and the RTL of the block.

module detection_box_regression_top_tb;
  import drb_pkg::*;

  localparam int CLK_HALF        = 2;
  localparam int DRAIN_CYCLES    = 40;
  localparam int NUM_PHASES      = 6;
  localparam int ITEMS_PER_PHASE = 185;
  localparam int TIMEOUT_NS      = 2_000_000;
  localparam int MAX_PRINTED     = 20;

  localparam int OUT_ORIG_LSB  = NUM_EDGES * EDGE_W;
  localparam int OUT_COMP_LSB  = OUT_ORIG_LSB + NUM_EDGES * ORIG_W;
  localparam int OUT_SCORE_LSB = OUT_COMP_LSB + COMP_W;
  localparam int OUT_SCALE_LSB = OUT_SCORE_LSB + 16;

  // register index with no register behind it
  localparam logic [CFG_IW-1:0] CFG_UNMAPPED = 2'd3;

  typedef enum int {RX_OPEN, RX_COIN, RX_PERIODIC, RX_BURSTY} rx_mode_e;

  typedef struct {
    logic               op;
    logic [COMP_W-1:0]  comp;
    logic [IDX_W-1:0]   idx;
    logic [SEL_W-1:0]   sel;
    logic [COEF_W-1:0]  cval;
    logic [COORD_W-1:0] left;
    logic [COORD_W-1:0] top;
    logic [COORD_W-1:0] bottom;
    logic [15:0]        score;
    logic [15:0]        scale;
    logic               last;
  } drb_word_t;

  typedef struct {
    logic [NUM_EDGES-1:0][EDGE_W-1:0] px;
    logic [NUM_EDGES-1:0][ORIG_W-1:0] orig;
    logic [COMP_W-1:0]                comp;
    logic [15:0]                      score;
    logic [15:0]                      scale;
  } refined_box_t;

  logic         clk = 1'b0;
  logic         rst_n;
  logic [127:0] in_tdata;
  logic         in_tuser;
  logic         in_tlast;
  logic         in_tvalid;
  logic         in_tready;
  logic [151:0] out_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [1:0]   cfg_index;
  logic [15:0]  cfg_data;

  detection_box_regression_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #(CLK_HALF) clk = ~clk;

  // predictor state
  logic [COEF_W-1:0]  coef_mem [MAX_COMPONENTS][TERMS][NUM_EDGES];
  longint             dot_acc [NUM_EDGES];
  int                 term_pos;
  logic [EDGE_W-1:0]  img_w;
  logic [EDGE_W-1:0]  img_h;
  logic [RATIO_W-1:0] ratio_recip;

  drb_word_t    pending_words[$];
  refined_box_t refined_q[$];
  drb_word_t    cur_word;

  int errors    = 0;
  int n_results = 0;
  int n_boxes   = 0;
  int n_loads   = 0;

  string px_name [NUM_EDGES] = '{"left", "top", "right", "bottom"};

  task automatic report_mismatch(input string what, input longint got, input longint want);
    errors++;
    if (errors <= MAX_PRINTED)
      $display("mismatch at %0t ns: %s got 0x%0h expected 0x%0h", $time, what, got, want);
  endtask

  // ---------------------------------------------------------------- predictor

  task automatic add_term(input logic [COMP_W-1:0] comp, input longint value);
    longint c;
    if (term_pos >= TERMS) return;
    if (comp < MAX_COMPONENTS) begin
      for (int s = 0; s < NUM_EDGES; s++) begin
        c = $signed(coef_mem[comp][term_pos][s]);
        dot_acc[s] += value * c;
      end
    end
    term_pos++;
  endtask

  function automatic logic [EDGE_W-1:0] floor_px(input longint acc);
    longint v;
    v = acc >>> FRAC_W;
    if (acc <= 0) return '0;
    return (v > 4095) ? 12'hFFF : EDGE_W'(v);
  endfunction

  function automatic logic [EDGE_W-1:0] cap_px(input longint acc, input logic [EDGE_W-1:0] limit);
    if (acc >= (longint'(limit) <<< FRAC_W)) return limit;
    if (acc <= 0) return '0;
    return EDGE_W'(acc >>> FRAC_W);
  endfunction

  function automatic logic [ORIG_W-1:0] orig_px(input logic [EDGE_W-1:0] e);
    logic [31:0] p;
    p = (32'(e) * 32'(ratio_recip)) >> RATIO_FR;
    return (p > 32'hFFFF) ? 16'hFFFF : p[ORIG_W-1:0];
  endfunction

  task automatic regress_word(input drb_word_t w);
    longint       l;
    longint       t;
    longint       b;
    refined_box_t r;
    if (w.op == OP_LOAD) begin
      n_loads++;
      if (w.comp < MAX_COMPONENTS && w.idx < TERMS) coef_mem[w.comp][w.idx][w.sel] = w.cval;
      return;
    end
    n_boxes++;
    l = $signed(w.left);
    t = $signed(w.top);
    b = $signed(w.bottom);
    // position 0 means a root box: height term first
    if (term_pos == 0) add_term(w.comp, b - t);
    add_term(w.comp, t);
    add_term(w.comp, l);
    if (!w.last) return;
    r.px[0] = floor_px(dot_acc[0]);
    r.px[1] = floor_px(dot_acc[1]);
    r.px[2] = cap_px(dot_acc[2], img_w);
    r.px[3] = cap_px(dot_acc[3], img_h);
    for (int s = 0; s < NUM_EDGES; s++) r.orig[s] = orig_px(r.px[s]);
    r.comp  = w.comp;
    r.score = w.score;
    r.scale = w.scale;
    refined_q.push_back(r);
    for (int s = 0; s < NUM_EDGES; s++) dot_acc[s] = 0;
    term_pos = 0;
  endtask

  // ---------------------------------------------------------------- stimulus

  function automatic logic [COORD_W-1:0] rand_coord();
    case ($urandom_range(0, 9))
      0:       return 16'($urandom);
      1:       return ($urandom_range(0, 1) != 0) ? 16'h8000 : 16'h7FFF;
      2:       return 16'($urandom_range(0, 16'h0FFF)) | 16'hF000;   // small negative
      default: return 16'($urandom_range(0, 16'h7FFF));
    endcase
  endfunction

  function automatic logic [COEF_W-1:0] rand_coef();
    case ($urandom_range(0, 9))
      0:       return $urandom;
      1:       return '0;
      2:       return ($urandom_range(0, 1) != 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      default: return 32'($urandom_range(0, 196608)) - 32'd98304;   // about +-1.5
    endcase
  endfunction

  task automatic push_load(input logic [COMP_W-1:0] comp, input logic [IDX_W-1:0] idx,
                           input logic [SEL_W-1:0] sel, input logic [COEF_W-1:0] val);
    drb_word_t w;
    w.op     = OP_LOAD;
    w.comp   = comp;
    w.idx    = idx;
    w.sel    = sel;
    w.cval   = val;
    w.left   = 16'($urandom);
    w.top    = 16'($urandom);
    w.bottom = 16'($urandom);
    w.score  = 16'($urandom);
    w.scale  = 16'($urandom);
    w.last   = 1'($urandom);
    pending_words.push_back(w);
  endtask

  task automatic push_box(input logic [COMP_W-1:0] comp, input logic [COORD_W-1:0] left,
                          input logic [COORD_W-1:0] top, input logic [COORD_W-1:0] bottom,
                          input logic [15:0] score, input logic [15:0] scale,
                          input logic last);
    drb_word_t w;
    w.op     = OP_BOX;
    w.comp   = comp;
    w.idx    = 5'($urandom);
    w.sel    = 2'($urandom);
    w.cval   = $urandom;
    w.left   = left;
    w.top    = top;
    w.bottom = bottom;
    w.score  = score;
    w.scale  = scale;
    w.last   = last;
    pending_words.push_back(w);
  endtask

  // one detection: root, some parts (now and then more than the terms hold),
  // coefficient reloads sprinkled in, occasional component switch per box
  task automatic push_detection(inout int count);
    int                parts;
    logic [COMP_W-1:0] comp;
    logic [IDX_W-1:0]  idx;
    parts = ($urandom_range(0, 9) == 0) ? $urandom_range(MAX_PARTS + 1, MAX_PARTS + 3)
                                        : $urandom_range(0, MAX_PARTS);
    comp = COMP_W'($urandom_range(0, MAX_COMPONENTS - 1));
    for (int k = 0; k <= parts; k++) begin
      if ($urandom_range(0, 9) == 0) begin
        idx = ($urandom_range(0, 4) == 0) ? IDX_W'($urandom_range(TERMS, 31))
                                          : IDX_W'($urandom_range(0, TERMS - 1));
        push_load(3'($urandom), idx, 2'($urandom), rand_coef());
        if (idx < TERMS) count++;
      end
      if ($urandom_range(0, 6) == 0) comp = COMP_W'($urandom_range(0, MAX_COMPONENTS - 1));
      push_box(comp, rand_coord(), rand_coord(), rand_coord(), 16'($urandom),
               16'($urandom), k == parts);
      count++;
    end
  endtask

  task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_IMAGE_WIDTH:  img_w = data[EDGE_W-1:0];
      CFG_IMAGE_HEIGHT: img_h = data[EDGE_W-1:0];
      CFG_RATIO_RECIP:  ratio_recip = data;
      default: ;
    endcase
  endtask

  function automatic logic [CFG_DW-1:0] rand_px_reg();
    return {4'($urandom), 12'($urandom_range(1, 4095))};
  endfunction

  task automatic wait_drained();
    while (pending_words.size() != 0 || in_tvalid || refined_q.size() != 0) @(posedge clk);
    // non-last boxes may still be in flight
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------- driver

  int burst_left = 1;
  int gap_left   = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) regress_word(cur_word);
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0 || pending_words.size() == 0) begin
          if (gap_left > 0) gap_left--;
          in_tvalid <= 1'b0;
        end else begin
          cur_word = pending_words.pop_front();
          in_tvalid <= 1'b1;
          in_tuser  <= cur_word.op;
          in_tlast  <= cur_word.last;
          in_tdata  <= {6'b0, cur_word.scale, cur_word.score, cur_word.bottom, cur_word.top,
                        cur_word.left, cur_word.cval, cur_word.sel, cur_word.idx,
                        cur_word.comp};
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  rx_mode_e rx_mode = RX_OPEN;
  int       rx_cnt  = 0;
  int       rx_hold = 0;

  always @(posedge clk) begin : rx_side
    refined_box_t want;
    logic         rdy;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (refined_q.size() == 0) begin
          report_mismatch("result word with none expected", longint'(out_tdata[63:0]),
                          longint'(0));
        end else begin
          want = refined_q.pop_front();
          n_results++;
          for (int s = 0; s < NUM_EDGES; s++) begin
            if (out_tdata[EDGE_W*s +: EDGE_W] !== want.px[s])
              report_mismatch(px_name[s], longint'(out_tdata[EDGE_W*s +: EDGE_W]),
                              longint'(want.px[s]));
            if (out_tdata[OUT_ORIG_LSB + ORIG_W*s +: ORIG_W] !== want.orig[s])
              report_mismatch({"orig_", px_name[s]},
                              longint'(out_tdata[OUT_ORIG_LSB + ORIG_W*s +: ORIG_W]),
                              longint'(want.orig[s]));
          end
          if (out_tdata[OUT_COMP_LSB +: COMP_W] !== want.comp)
            report_mismatch("out_component", longint'(out_tdata[OUT_COMP_LSB +: COMP_W]),
                            longint'(want.comp));
          if (out_tdata[OUT_SCORE_LSB +: 16] !== want.score)
            report_mismatch("out_score", longint'(out_tdata[OUT_SCORE_LSB +: 16]),
                            longint'(want.score));
          if (out_tdata[OUT_SCALE_LSB +: 16] !== want.scale)
            report_mismatch("out_scale", longint'(out_tdata[OUT_SCALE_LSB +: 16]),
                            longint'(want.scale));
        end
      end
      if (rx_cnt == 0) begin
        rx_mode = rx_mode_e'($urandom_range(0, 3));
        rx_cnt  = $urandom_range(50, 400);
      end else begin
        rx_cnt--;
      end
      case (rx_mode)
        RX_OPEN:     rdy = 1'b1;
        RX_COIN:     rdy = 1'($urandom);
        RX_PERIODIC: rdy = (rx_cnt % 8) == 0;
        default: begin
          if (rx_hold > 0) begin
            rx_hold--;
            rdy = 1'b0;
          end else begin
            rdy = 1'b1;
            if ($urandom_range(0, 3) == 0) rx_hold = $urandom_range(1, 16);
          end
        end
      endcase
      out_tready <= rdy;
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    int count;
    rst_n      = 1'b0;
    in_tdata   = '0;
    in_tuser   = 1'b0;
    in_tlast   = 1'b0;
    in_tvalid  = 1'b0;
    out_tready = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    for (int s = 0; s < NUM_EDGES; s++) dot_acc[s] = 0;
    term_pos    = 0;
    img_w       = RST_IMAGE_WIDTH;
    img_h       = RST_IMAGE_HEIGHT;
    ratio_recip = RST_RATIO_RECIP;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // every coefficient word gets written before any box reads it
    for (int c = 0; c < MAX_COMPONENTS; c++)
      for (int t = 0; t < TERMS; t++)
        for (int s = 0; s < NUM_EDGES; s++)
          push_load(COMP_W'(c), IDX_W'(t), SEL_W'(s), rand_coef());

    // directed: coefficient and coordinate extremes on one-box detections
    push_load(3'd0, 5'd0, 2'd0, 32'h7FFF_FFFF);
    push_load(3'd0, 5'd0, 2'd1, 32'h8000_0000);
    push_box(3'd0, 16'h8000, 16'h8000, 16'h7FFF, 16'h8000, 16'hFFFF, 1'b1);
    push_box(3'd0, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h0000, 1'b1);
    push_box(3'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1);
    push_box(3'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
    // root plus ten parts overruns the terms; loads in the middle, two ignored
    for (int k = 0; k <= MAX_PARTS + 2; k++) begin
      if (k == 3) push_load(3'd7, 5'd5, 2'd2, rand_coef());
      if (k == 4) push_load(3'd7, 5'd31, 2'd3, rand_coef());
      if (k == 5) push_load(3'd6, IDX_W'(TERMS), 2'd0, rand_coef());
      push_box(3'd7, rand_coord(), rand_coord(), rand_coord(), 16'h1234, 16'h8000,
               k == MAX_PARTS + 2);
    end
    // component changes from box to box
    push_box(3'd2, rand_coord(), rand_coord(), rand_coord(), 16'($urandom), 16'($urandom),
             1'b0);
    push_box(3'd5, rand_coord(), rand_coord(), rand_coord(), 16'($urandom), 16'($urandom),
             1'b0);
    push_box(3'd3, rand_coord(), rand_coord(), rand_coord(), 16'($urandom), 16'($urandom),
             1'b1);
    wait_drained();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        1: begin
          write_reg(CFG_IMAGE_WIDTH, 16'd4095);
          write_reg(CFG_IMAGE_HEIGHT, 16'd4095);
          write_reg(CFG_RATIO_RECIP, 16'hFFFF);
        end
        2: begin
          write_reg(CFG_IMAGE_WIDTH, 16'd1);
          write_reg(CFG_IMAGE_HEIGHT, 16'd1);
          write_reg(CFG_RATIO_RECIP, 16'h0000);
        end
        4: begin
          write_reg(CFG_IMAGE_WIDTH, 16'd4095);
          write_reg(CFG_IMAGE_HEIGHT, 16'd1);
          write_reg(CFG_RATIO_RECIP, 16'd1);
        end
        3, 5: begin
          write_reg(CFG_IMAGE_WIDTH, rand_px_reg());
          write_reg(CFG_IMAGE_HEIGHT, rand_px_reg());
          write_reg(CFG_RATIO_RECIP, 16'($urandom));
          write_reg(CFG_UNMAPPED, 16'($urandom));
        end
        default: ;
      endcase
      if (ph > 0) cfg_valid <= 1'b0;
      count = 0;
      while (count < ITEMS_PER_PHASE) push_detection(count);
      wait_drained();
    end

    $display("Checked %0d refined boxes from %0d box words and %0d coefficient loads",
             n_results, n_boxes, n_loads);
    $display("over %0d register settings, with bursty input and stalled output", NUM_PHASES);
    if (errors == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("timeout: %0d expected results outstanding", refined_q.size());
    $display("FAIL");
    $finish;
  end

endmodule
